// ===== hdl/sprqf_pkg.sv =====
package sprqf_pkg;

   // default sizes
   localparam int SLOTS_DEF       = 4;
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int MAX_PAYLOAD_DEF = 32;
   localparam int CMD_QUEUE_DEPTH = 4;

   // report ids and frame constants
   localparam logic [7:0] OPCODE_RESET   = 8'hE3;
   localparam logic [7:0] ID_LAND        = 8'h9F;
   localparam logic [7:0] ID_SETTINGS    = 8'h87;
   localparam logic [7:0] ID_HAPTIC      = 8'h82;
   localparam logic [7:0] ID_HAPTIC_ANY  = 8'h80;
   localparam logic [7:0] SET_LAND_A     = 8'h2D;
   localparam logic [7:0] SET_LAND_B     = 8'h09;
   localparam logic [7:0] AMP_BLOCK_A    = 8'h18;
   localparam logic [7:0] AMP_BLOCK_B    = 8'h2E;
   localparam logic [7:0] AMP_BLOCK_C    = 8'h34;
   localparam logic [7:0] AMP_BLOCK_D    = 8'h35;
   localparam logic [7:0] FORM_TYPE01    = 8'h01;
   localparam logic [7:0] FORM_LEGACY    = 8'h05;
   localparam logic [7:0] SLOT_ALL       = 8'hFF;

   // register indexes
   localparam logic [1:0] CSR_OPCODE    = 2'd0;
   localparam logic [1:0] CSR_AMP_BLOCK = 2'd1;
   localparam logic [1:0] CSR_ALL_SET   = 2'd2;

   typedef enum logic [1:0] {
      MODE_ENQ    = 2'd0,
      MODE_FLUSH  = 2'd1,
      MODE_CANCEL = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_TAKEN     = 3'd0,
      KIND_COMMITTED = 3'd1,
      KIND_REJECTED  = 3'd2,
      KIND_FRAME     = 3'd3,
      KIND_EMPTY     = 3'd4,
      KIND_CANCELLED = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      CMD_REPLY,
      CMD_STORE,
      CMD_COMMIT,
      CMD_FLUSH,
      CMD_CANCEL
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      kind_type    kind;
      logic        store;
      logic        all_slots;
      logic [7:0]  slot;
      logic [7:0]  rid;
      logic [5:0]  len;
      logic [4:0]  bidx;
      logic [7:0]  data;
   } cmd_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic       amp_block;
      logic       all_settings;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rid;
      logic [5:0] len;
      logic       active;
   } meta_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REPLY,
      ST_CMT_SLOT,
      ST_CMT_COPY,
      ST_CMT_META,
      ST_FL_CHECK,
      ST_FL_META,
      ST_FL_HDR,
      ST_FL_DATA,
      ST_CN_SLOT,
      ST_CN_SCAN,
      ST_CN_CHECK
   } state_type;

endpackage

// ===== hdl/sprqf_ram.sv =====
module sprqf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port that holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sprqf_front.sv =====
module sprqf_front #(
   parameter int SLOTS       = sprqf_pkg::SLOTS_DEF,
   parameter int MAX_PAYLOAD = sprqf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   output logic              cmd_valid,
   output sprqf_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import sprqf_pkg::*;

   localparam int QW = $clog2(CMD_QUEUE_DEPTH);

   cmd_type        q_ff [CMD_QUEUE_DEPTH];
   logic [QW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QW:0]    count_ff, count_in;

   logic [7:0]  f_slot;
   logic [7:0]  f_rid;
   logic [5:0]  f_len;
   logic [4:0]  f_bidx;
   logic [7:0]  f_data;
   mode_type    f_mode;
   logic        slot_ok;
   logic        slot_all;
   logic [5:0]  len_sat;
   logic        push;
   logic        accept;
   cmd_type     cmd_new;

   // unpack request fields
   assign f_slot = req_tdata[7:0];
   assign f_rid  = req_tdata[15:8];
   assign f_len  = req_tdata[21:16];
   assign f_bidx = req_tdata[26:22];
   assign f_data = req_tdata[34:27];
   assign f_mode = mode_type'(req_tuser);

   assign slot_ok  = f_slot < 8'(SLOTS);
   assign slot_all = f_slot == SLOT_ALL;
   assign len_sat  = (f_len > 6'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : f_len;

   // classify the request into a back-end command
   always_comb begin
      cmd_new.op        = CMD_REPLY;
      cmd_new.kind      = KIND_TAKEN;
      cmd_new.store     = 1'b0;
      cmd_new.all_slots = slot_all;
      cmd_new.slot      = f_slot;
      cmd_new.rid       = f_rid;
      cmd_new.len       = len_sat;
      cmd_new.bidx      = f_bidx;
      cmd_new.data      = f_data;
      push              = 1'b1;
      unique case (f_mode)
         MODE_ENQ: begin
            if (!slot_ok && !slot_all) begin
               cmd_new.kind = KIND_REJECTED;
            end else if (len_sat == 6'd0) begin
               cmd_new.op   = CMD_COMMIT;
               cmd_new.kind = KIND_COMMITTED;
            end else if ({1'b0, f_bidx} >= len_sat) begin
               cmd_new.kind = KIND_TAKEN;
            end else if ({1'b0, f_bidx} == len_sat - 6'd1) begin
               cmd_new.op    = CMD_COMMIT;
               cmd_new.kind  = KIND_COMMITTED;
               cmd_new.store = 1'b1;
            end else begin
               cmd_new.op    = CMD_STORE;
               cmd_new.store = 1'b1;
            end
         end
         MODE_FLUSH: begin
            if (!slot_ok) begin
               cmd_new.kind = KIND_REJECTED;
            end else begin
               cmd_new.op = CMD_FLUSH;
            end
         end
         MODE_CANCEL: begin
            if (!slot_ok && !slot_all) begin
               cmd_new.kind = KIND_REJECTED;
            end else begin
               cmd_new.op   = CMD_CANCEL;
               cmd_new.kind = KIND_CANCELLED;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // command queue control
   assign req_tready = count_ff != (QW+1)'(CMD_QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready && push;
   assign cmd_valid  = count_ff != '0;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (accept && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== hdl/sprqf_back.sv =====
module sprqf_back #(
   parameter int SLOTS       = sprqf_pkg::SLOTS_DEF,
   parameter int QUEUE_DEPTH = sprqf_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_PAYLOAD = sprqf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  sprqf_pkg::cfg_type cfg,
   input  logic               cmd_valid,
   input  sprqf_pkg::cmd_type cmd,
   output logic               cmd_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [2:0]         rsp_tuser,
   output logic               rsp_tlast
);
   import sprqf_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int EW = $clog2(SLOTS * QUEUE_DEPTH);
   localparam int AW = $clog2(SLOTS * QUEUE_DEPTH * MAX_PAYLOAD);
   localparam int JW = $clog2(MAX_PAYLOAD);
   localparam int MW = $bits(meta_type);

   function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [EW-1:0] ent_addr(input logic [SW-1:0] s,
                                               input logic [PW-1:0] p);
      return (EW'(s) * EW'(QUEUE_DEPTH)) + EW'(p);
   endfunction

   function automatic logic [AW-1:0] pay_addr(input logic [EW-1:0] e,
                                               input logic [JW-1:0] j);
      return (AW'(e) * AW'(MAX_PAYLOAD)) + AW'(j);
   endfunction

   state_type       state_ff, state_in;
   cmd_type         cmd_ff, cmd_in;
   kind_type        rkind_ff, rkind_in;
   logic [SW-1:0]   s_ff, s_in;
   logic [SW-1:0]   s_last_ff, s_last_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [JW-1:0]   j_ff, j_in;
   logic [2:0]      hdr_ff, hdr_in;
   logic [7:0]      rid_ff, rid_in;
   logic [5:0]      len_ff, len_in;
   logic [7:0]      d0_ff, d0_in;
   logic            active_ff, active_in;
   logic [PW-1:0]   head_ff [SLOTS];
   logic [PW-1:0]   head_in [SLOTS];
   logic [PW-1:0]   tail_ff [SLOTS];
   logic [PW-1:0]   tail_in [SLOTS];
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_kind_ff, rsp_kind_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            stg_we, stg_re;
   logic [JW-1:0]   stg_waddr, stg_raddr;
   logic [7:0]      stg_rdata;
   logic            pay_we, pay_re;
   logic [AW-1:0]   pay_waddr, pay_raddr;
   logic [7:0]      pay_rdata;
   logic            meta_we, meta_re;
   logic [EW-1:0]   meta_waddr, meta_raddr;
   meta_type        meta_wdata, meta_rdata;
   logic [MW-1:0]   meta_rbits;

   logic [PW-1:0]   hd, tl;
   logic            out_free;
   logic            last_slot;
   logic            amp, land;
   logic [2:0]      hdr_end;
   logic [7:0]      hdr_byte;
   logic            copy_end, data_end;

   assign hd        = head_ff[s_ff];
   assign tl        = tail_ff[s_ff];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_slot = s_ff == s_last_ff;
   assign copy_end  = 6'(j_ff) == cmd_ff.len - 6'd1;
   assign data_end  = 6'(j_ff) == len_ff - 6'd1;
   assign meta_rdata = meta_type'(meta_rbits);

   // frame form selection
   assign amp  = (len_ff != 6'd0) && (d0_ff == AMP_BLOCK_A || d0_ff == AMP_BLOCK_B ||
                 d0_ff == AMP_BLOCK_C || d0_ff == AMP_BLOCK_D);
   assign land = (rid_ff == ID_LAND) ||
                 (rid_ff == ID_SETTINGS && len_ff != 6'd0 && d0_ff == SET_LAND_A) ||
                 (rid_ff == ID_SETTINGS && len_ff == 6'd3 && d0_ff == SET_LAND_B) ||
                 (cfg.amp_block && rid_ff == ID_SETTINGS && amp) ||
                 (cfg.all_settings && rid_ff == ID_SETTINGS);
   assign hdr_end = land ? 3'd4 : 3'd3;

   // header byte select
   always_comb begin
      case (hdr_ff)
         3'd0:    hdr_byte = cfg.opcode;
         3'd1:    hdr_byte = {2'b00, len_ff} + (land ? 8'd2 : 8'd1);
         3'd2:    hdr_byte = land ? FORM_TYPE01 : FORM_LEGACY;
         3'd3:    hdr_byte = rid_ff;
         default: hdr_byte = {2'b00, len_ff};
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  CMD_COMMIT: state_in = ST_CMT_SLOT;
                  CMD_FLUSH:  state_in = ST_FL_CHECK;
                  CMD_CANCEL: state_in = ST_CN_SLOT;
                  default:    state_in = ST_REPLY;
               endcase
            end
         end
         ST_REPLY: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_CMT_SLOT: begin
            state_in = (cmd_ff.len == 6'd0) ? ST_CMT_META : ST_CMT_COPY;
         end
         ST_CMT_COPY: begin
            if (copy_end) state_in = ST_CMT_META;
         end
         ST_CMT_META: begin
            state_in = last_slot ? ST_REPLY : ST_CMT_SLOT;
         end
         ST_FL_CHECK: begin
            state_in = (tl == hd) ? ST_REPLY : ST_FL_META;
         end
         ST_FL_META: begin
            state_in = (meta_rdata.rid == 8'd0) ? ST_FL_CHECK : ST_FL_HDR;
         end
         ST_FL_HDR: begin
            if (out_free && hdr_ff == hdr_end) begin
               state_in = (len_ff == 6'd0) ? ST_IDLE : ST_FL_DATA;
            end
         end
         ST_FL_DATA: begin
            if (out_free && data_end) state_in = ST_IDLE;
         end
         ST_CN_SLOT: begin
            state_in = ST_CN_SCAN;
         end
         ST_CN_SCAN: begin
            if (pos_ff != hd) begin
               state_in = ST_CN_CHECK;
            end else begin
               state_in = last_slot ? ST_REPLY : ST_CN_SLOT;
            end
         end
         ST_CN_CHECK: begin
            state_in = ST_CN_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cmd_pop      = 1'b0;
      cmd_in       = cmd_ff;
      rkind_in     = rkind_ff;
      s_in         = s_ff;
      s_last_in    = s_last_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      hdr_in       = hdr_ff;
      rid_in       = rid_ff;
      len_in       = len_ff;
      d0_in        = d0_ff;
      active_in    = active_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      stg_we       = 1'b0;
      stg_waddr    = JW'(cmd.bidx);
      stg_re       = 1'b0;
      stg_raddr    = '0;
      pay_we       = 1'b0;
      pay_waddr    = pay_addr(ent_addr(s_ff, hd), j_ff);
      pay_re       = 1'b0;
      pay_raddr    = pay_addr(ent_addr(s_ff, pos_ff), '0);
      meta_we      = 1'b0;
      meta_waddr   = ent_addr(s_ff, hd);
      meta_wdata   = '{rid: cmd_ff.rid, len: cmd_ff.len, active: active_ff};
      meta_re      = 1'b0;
      meta_raddr   = ent_addr(s_ff, pos_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd;
               rkind_in  = cmd.kind;
               stg_we    = cmd.store;
               s_in      = cmd.all_slots ? '0 : SW'(cmd.slot);
               s_last_in = cmd.all_slots ? SW'(SLOTS - 1) : SW'(cmd.slot);
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = rkind_ff;
               rsp_byte_in  = 8'd0;
               rsp_last_in  = 1'b1;
            end
         end
         ST_CMT_SLOT: begin
            j_in      = '0;
            active_in = 1'b0;
            stg_re    = cmd_ff.len != 6'd0;
            stg_raddr = '0;
         end
         ST_CMT_COPY: begin
            pay_we = 1'b1;
            if (stg_rdata != 8'd0 &&
                (cmd_ff.rid == ID_HAPTIC_ANY ||
                 (cmd_ff.rid == ID_HAPTIC && j_ff >= JW'(2)))) begin
               active_in = 1'b1;
            end
            if (!copy_end) begin
               j_in      = j_ff + 1'b1;
               stg_re    = 1'b1;
               stg_raddr = j_ff + 1'b1;
            end
         end
         ST_CMT_META: begin
            meta_we = 1'b1;
            if (pos_next(hd) == tl) begin
               tail_in[s_ff] = pos_next(tl);
            end
            head_in[s_ff] = pos_next(hd);
            if (!last_slot) s_in = s_ff + 1'b1;
         end
         ST_FL_CHECK: begin
            if (tl == hd) begin
               rkind_in = KIND_EMPTY;
            end else begin
               meta_re       = 1'b1;
               meta_raddr    = ent_addr(s_ff, tl);
               pay_re        = 1'b1;
               pay_raddr     = pay_addr(ent_addr(s_ff, tl), '0);
               pos_in        = tl;
               tail_in[s_ff] = pos_next(tl);
            end
         end
         ST_FL_META: begin
            rid_in = meta_rdata.rid;
            len_in = meta_rdata.len;
            d0_in  = pay_rdata;
            hdr_in = '0;
         end
         ST_FL_HDR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FRAME;
               rsp_byte_in  = hdr_byte;
               rsp_last_in  = (len_ff == 6'd0) && (hdr_ff == hdr_end);
               hdr_in       = hdr_ff + 1'b1;
               if (hdr_ff == hdr_end) begin
                  j_in   = '0;
                  pay_re = len_ff != 6'd0;
               end
            end
         end
         ST_FL_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FRAME;
               rsp_byte_in  = pay_rdata;
               rsp_last_in  = data_end;
               if (!data_end) begin
                  j_in      = j_ff + 1'b1;
                  pay_re    = 1'b1;
                  pay_raddr = pay_addr(ent_addr(s_ff, pos_ff), j_ff + 1'b1);
               end
            end
         end
         ST_CN_SLOT: begin
            pos_in = tl;
         end
         ST_CN_SCAN: begin
            if (pos_ff != hd) begin
               meta_re = 1'b1;
            end else if (!last_slot) begin
               s_in = s_ff + 1'b1;
            end
         end
         ST_CN_CHECK: begin
            meta_we    = meta_rdata.active;
            meta_waddr = ent_addr(s_ff, pos_ff);
            meta_wdata = '{rid: 8'd0, len: meta_rdata.len, active: 1'b0};
            pos_in     = pos_next(pos_ff);
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rkind_ff    <= rkind_in;
      s_ff        <= s_in;
      s_last_ff   <= s_last_in;
      pos_ff      <= pos_in;
      j_ff        <= j_in;
      hdr_ff      <= hdr_in;
      rid_ff      <= rid_in;
      len_ff      <= len_in;
      d0_ff       <= d0_in;
      active_ff   <= active_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // staging buffer for the message being received
   sprqf_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_stage (
      .clock   (clock),
      .wr_en   (stg_we),
      .wr_addr (stg_waddr),
      .wr_data (cmd.data),
      .rd_en   (stg_re),
      .rd_addr (stg_raddr),
      .rd_data (stg_rdata)
   );

   // ring entry payloads
   sprqf_ram #(.WIDTH(8), .DEPTH(SLOTS * QUEUE_DEPTH * MAX_PAYLOAD)) u_payload (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (stg_rdata),
      .rd_en   (pay_re),
      .rd_addr (pay_raddr),
      .rd_data (pay_rdata)
   );

   // ring entry id, length and active flag
   sprqf_ram #(.WIDTH(MW), .DEPTH(SLOTS * QUEUE_DEPTH)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (meta_raddr),
      .rd_data (meta_rbits)
   );

endmodule

// ===== hdl/per_slot_relay_queue_framer_core.sv =====
// enqueue byte request: the last byte commits the message to each target ring
// (payload copy through the staging RAM) before the answer; flush: void entries
// are skipped, then 4 or 5 header bytes and len data bytes at one byte per
// cycle while the receiver is ready; cancel voids active queued entries per ring
// a 4-entry command queue lets requests arrive while the back end works
// reset (synchronous): rings empty, control registers reset, memories untouched
module per_slot_relay_queue_framer_core #(
   parameter int SLOTS       = sprqf_pkg::SLOTS_DEF,
   parameter int QUEUE_DEPTH = sprqf_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_PAYLOAD = sprqf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot, report_id, payload_length, byte_index, data_byte, zero pad
   input  logic [39:0] req_tdata,
   // mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_byte
   output logic [7:0]  rsp_tdata,
   // kind
   output logic [2:0]  rsp_tuser,
   // frame_last
   output logic        rsp_tlast
);
   import sprqf_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OPCODE:    cfg_in.opcode       = csr_data;
            CSR_AMP_BLOCK: cfg_in.amp_block    = csr_data[0];
            CSR_ALL_SET:   cfg_in.all_settings = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{opcode: OPCODE_RESET, amp_block: 1'b1, all_settings: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sprqf_front #(.SLOTS(SLOTS), .MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   sprqf_back #(
      .SLOTS       (SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import sprqf_pkg::*;

   localparam int NSLOT  = 4;
   localparam int DEPTH  = 32;
   localparam int MAXLEN = 32;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      mode_type   mode;
      logic [7:0] slot;
      logic [7:0] rid;
      logic [5:0] len;
      logic [4:0] bidx;
      logic [7:0] data;
   } relay_req_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] fbyte;
      logic       last;
   } relay_rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   per_slot_relay_queue_framer_core i_dut (.*);

   always #5 clock = ~clock;

   // predicted ring contents and settings
   logic [7:0] ring_payload [NSLOT][DEPTH][MAXLEN];
   logic [7:0] ring_rid     [NSLOT][DEPTH];
   logic [5:0] ring_len     [NSLOT][DEPTH];
   logic       ring_active  [NSLOT][DEPTH];
   int         ring_wr      [NSLOT];
   int         ring_rd      [NSLOT];
   logic [7:0] staging      [MAXLEN];
   logic [7:0] cfg_opcode = OPCODE_RESET;
   logic       cfg_amp = 1'b1;
   logic       cfg_all = 1'b0;

   relay_req_type pending_reqs[$];
   relay_rsp_type expected_rsps[$];
   relay_req_type cur_req;
   int send_idle = 0;
   int recv_stall = 0;
   int errors = 0;
   int reqs_sent = 0;
   int rsps_seen = 0;
   int frames_seen = 0;
   int cycles = 0;

   function automatic void expect_rsp(kind_type k, logic [7:0] b, logic l);
      relay_rsp_type r;
      r.kind = k;
      r.fbyte = b;
      r.last = l;
      expected_rsps.push_back(r);
   endfunction

   // store the staged message into one ring or all of them
   function automatic void commit_message(logic [7:0] slot, logic [7:0] rid, int len);
      logic act;
      int s0, s1, nx;
      act = 1'b0;
      if (rid == ID_HAPTIC) begin
         for (int j = 2; j < len; j++) if (staging[j] != 0) act = 1'b1;
      end else if (rid == ID_HAPTIC_ANY) begin
         for (int j = 0; j < len; j++) if (staging[j] != 0) act = 1'b1;
      end
      s0 = (slot == SLOT_ALL) ? 0 : slot;
      s1 = (slot == SLOT_ALL) ? NSLOT : slot + 1;
      for (int s = s0; s < s1; s++) begin
         nx = (ring_wr[s] + 1) % DEPTH;
         if (nx == ring_rd[s]) ring_rd[s] = (ring_rd[s] + 1) % DEPTH;
         ring_rid[s][ring_wr[s]] = rid;
         ring_len[s][ring_wr[s]] = 6'(len);
         ring_active[s][ring_wr[s]] = act;
         for (int j = 0; j < len; j++) ring_payload[s][ring_wr[s]][j] = staging[j];
         ring_wr[s] = nx;
      end
   endfunction

   // pop the next live entry and build its on-air frame, or expect an empty reply
   function automatic void flush_ring(int s);
      int guard, t, rl, total, k;
      logic [7:0] rid, d0;
      logic amp, land;
      logic [7:0] hdr [5];
      int nh;
      guard = DEPTH;
      while (ring_rd[s] != ring_wr[s] && guard > 0) begin
         guard--;
         t = ring_rd[s];
         ring_rd[s] = (t + 1) % DEPTH;
         rid = ring_rid[s][t];
         if (rid == 0) continue;
         rl = ring_len[s][t];
         if (rl > MAXLEN) rl = MAXLEN;
         d0 = ring_payload[s][t][0];
         amp = rl >= 1 && (d0 == AMP_BLOCK_A || d0 == AMP_BLOCK_B ||
                           d0 == AMP_BLOCK_C || d0 == AMP_BLOCK_D);
         land = rid == ID_LAND ||
                (rid == ID_SETTINGS && rl >= 1 && d0 == SET_LAND_A) ||
                (rid == ID_SETTINGS && rl == 3 && d0 == SET_LAND_B) ||
                (cfg_amp && rid == ID_SETTINGS && amp) ||
                (cfg_all && rid == ID_SETTINGS);
         hdr[0] = cfg_opcode;
         hdr[3] = rid;
         if (land) begin
            hdr[1] = 8'(2 + rl);
            hdr[2] = FORM_TYPE01;
            hdr[4] = 8'(rl);
            nh = 5;
         end else begin
            hdr[1] = 8'(1 + rl);
            hdr[2] = FORM_LEGACY;
            nh = 4;
         end
         total = nh + rl;
         k = 0;
         for (int j = 0; j < nh; j++, k++) expect_rsp(KIND_FRAME, hdr[j], k == total - 1);
         for (int j = 0; j < rl; j++, k++)
            expect_rsp(KIND_FRAME, ring_payload[s][t][j], k == total - 1);
         return;
      end
      expect_rsp(KIND_EMPTY, 8'h00, 1'b1);
   endfunction

   // expected responses for one accepted request
   function automatic void predict_request(relay_req_type r);
      logic ok;
      int len;
      ok = r.slot < NSLOT;
      case (r.mode)
         MODE_ENQ: begin
            len = (r.len > MAXLEN) ? MAXLEN : r.len;
            if (!ok && r.slot != SLOT_ALL) expect_rsp(KIND_REJECTED, 8'h00, 1'b1);
            else if (len == 0) begin
               commit_message(r.slot, r.rid, 0);
               expect_rsp(KIND_COMMITTED, 8'h00, 1'b1);
            end else if (r.bidx >= len) expect_rsp(KIND_TAKEN, 8'h00, 1'b1);
            else begin
               staging[r.bidx] = r.data;
               if (r.bidx == len - 1) begin
                  commit_message(r.slot, r.rid, len);
                  expect_rsp(KIND_COMMITTED, 8'h00, 1'b1);
               end else expect_rsp(KIND_TAKEN, 8'h00, 1'b1);
            end
         end
         MODE_FLUSH: begin
            if (!ok) expect_rsp(KIND_REJECTED, 8'h00, 1'b1);
            else flush_ring(r.slot);
         end
         MODE_CANCEL: begin
            if (!ok && r.slot != SLOT_ALL) expect_rsp(KIND_REJECTED, 8'h00, 1'b1);
            else begin
               for (int s = 0; s < NSLOT; s++) begin
                  if (ok && s != r.slot) continue;
                  for (int i = ring_rd[s]; i != ring_wr[s]; i = (i + 1) % DEPTH)
                     if (ring_active[s][i]) begin
                        ring_rid[s][i] = 8'h00;
                        ring_active[s][i] = 1'b0;
                     end
               end
               expect_rsp(KIND_CANCELLED, 8'h00, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_request(cur_req);
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
               cur_req = pending_reqs.pop_front();
               req_tdata <= {5'b0, cur_req.data, cur_req.bidx, cur_req.len,
                             cur_req.rid, cur_req.slot};
               req_tuser <= cur_req.mode;
               req_tvalid <= 1'b1;
               reqs_sent++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      relay_rsp_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsps_seen++;
         if (rsp_tuser == KIND_FRAME && rsp_tlast) frames_seen++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected response kind %0d byte %h last %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_tuser != e.kind || rsp_tdata != e.fbyte || rsp_tlast != e.last) begin
               errors++;
               $display("%0t: expected kind %0d byte %h last %b, got kind %0d byte %h last %b",
                        $time, e.kind, e.fbyte, e.last, rsp_tuser, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   task automatic add_req(mode_type m, int slot, int rid, int len, int bidx, int data);
      relay_req_type r;
      r.mode = m;
      r.slot = 8'(slot);
      r.rid = 8'(rid);
      r.len = 6'(len);
      r.bidx = 5'(bidx);
      r.data = 8'(data);
      pending_reqs.push_back(r);
   endtask

   // one whole message, bytes in order; a zero length is a single request
   task automatic add_message(int slot, int rid, int len, int first);
      int n, d;
      n = (len > MAXLEN) ? MAXLEN : len;
      if (n == 0) add_req(MODE_ENQ, slot, rid, len, $urandom_range(31), $urandom_range(255));
      for (int i = 0; i < n; i++) begin
         d = ($urandom_range(2) == 0) ? 0 : $urandom_range(255);
         add_req(MODE_ENQ, slot, rid, len, i, (i == 0) ? first : d);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_OPCODE:    cfg_opcode = val;
         CSR_AMP_BLOCK: cfg_amp = val[0];
         CSR_ALL_SET:   cfg_all = val[0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random traffic: mostly whole messages, flushes and cancels, some noise
   task automatic add_random(int count);
      int rid, first, len, slot, firsts [7];
      firsts = '{SET_LAND_A, SET_LAND_B, AMP_BLOCK_A, AMP_BLOCK_B, AMP_BLOCK_C,
                 AMP_BLOCK_D, 0};
      for (int n = 0; n < count; ) begin
         slot = ($urandom_range(7) == 0) ? SLOT_ALL : $urandom_range(NSLOT - 1);
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               case ($urandom_range(7))
                  0: rid = ID_LAND;
                  1, 2: rid = ID_SETTINGS;
                  3: rid = ID_HAPTIC;
                  4: rid = ID_HAPTIC_ANY;
                  5: rid = 0;
                  default: rid = $urandom_range(255);
               endcase
               case ($urandom_range(9))
                  0: len = 0;
                  1: len = $urandom_range(MAXLEN);
                  2: len = 3;
                  default: len = $urandom_range(1, 6);
               endcase
               first = $urandom_range(6);
               first = (first == 6) ? $urandom_range(255) : firsts[first];
               add_message(slot, rid, len, first);
               n += (len == 0) ? 1 : len;
            end
            4, 5, 6: begin
               add_req(MODE_FLUSH, $urandom_range(NSLOT - 1), 0, 0, 0, 0);
               n++;
            end
            7: begin
               add_req(MODE_CANCEL, slot, 0, 0, 0, 0);
               n++;
            end
            default: begin
               case ($urandom_range(4))
                  0: add_req(MODE_ENQ, $urandom_range(NSLOT, 254), $urandom_range(255),
                             $urandom_range(63), $urandom_range(31), $urandom_range(255));
                  1: add_req(MODE_FLUSH, $urandom_range(NSLOT, 255), 0, 0, 0, 0);
                  2: add_req(MODE_CANCEL, $urandom_range(NSLOT, 254), 0, 0, 0, 0);
                  3: add_req(MODE_NONE, $urandom_range(255), $urandom_range(255),
                             $urandom_range(63), $urandom_range(31), $urandom_range(255));
                  default: add_req(MODE_ENQ, slot, $urandom_range(255), $urandom_range(1, 8),
                                   $urandom_range(8, 31), $urandom_range(255));
               endcase
               n++;
            end
         endcase
      end
   endtask

   initial begin
      for (int s = 0; s < NSLOT; s++) begin
         ring_wr[s] = 0;
         ring_rd[s] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: a full-length broadcast first so every staging byte is written
      for (int i = 0; i < MAXLEN; i++)
         add_req(MODE_ENQ, SLOT_ALL, ID_SETTINGS, 63, i, (i == 0) ? SET_LAND_A : (i % 2) * 255);
      add_req(MODE_FLUSH, 0, 0, 0, 0, 0);
      add_message(1, ID_LAND, 0, 0);
      add_message(1, ID_SETTINGS, 3, SET_LAND_B);
      add_message(1, ID_SETTINGS, 2, AMP_BLOCK_C);
      add_message(1, ID_HAPTIC, 3, 0);
      add_message(2, ID_HAPTIC_ANY, 2, 0);
      add_message(1, 0, 1, 7);
      add_req(MODE_ENQ, 1, ID_HAPTIC, 2, 5, 8'hAA);
      add_req(MODE_CANCEL, 1, 0, 0, 0, 0);
      add_req(MODE_CANCEL, SLOT_ALL, 0, 0, 0, 0);
      add_req(MODE_ENQ, 7, 1, 1, 0, 1);
      add_req(MODE_FLUSH, SLOT_ALL, 0, 0, 0, 0);
      add_req(MODE_CANCEL, 9, 0, 0, 0, 0);
      add_req(MODE_NONE, 0, 0, 0, 0, 0);
      for (int i = 0; i < 6; i++) add_req(MODE_FLUSH, 1, 0, 0, 0, 0);
      wait_idle();

      // phases: settings change, then traffic under a given idling pattern
      write_csr(CSR_OPCODE, 8'h00);
      write_csr(CSR_AMP_BLOCK, 8'h00);
      write_csr(CSR_ALL_SET, 8'h00);
      add_random(75);
      wait_idle();

      write_csr(CSR_OPCODE, 8'hFF);
      write_csr(CSR_ALL_SET, 8'h01);
      send_idle = 65;
      add_random(75);
      wait_idle();

      write_csr(CSR_OPCODE, 8'($urandom_range(255)));
      write_csr(CSR_AMP_BLOCK, 8'h01);
      write_csr(CSR_ALL_SET, 8'h00);
      send_idle = 0;
      recv_stall = 65;
      add_random(75);
      wait_idle();

      write_csr(CSR_ALL_SET, 8'h01);
      send_idle = 38;
      recv_stall = 38;
      add_random(75);
      for (int s = 0; s < NSLOT; s++) add_req(MODE_FLUSH, s, 0, 0, 0, 0);
      wait_idle();

      $display("sent %0d requests, checked %0d responses carrying %0d frames",
               reqs_sent, rsps_seen, frames_seen);
      $display("covered four settings phases under free, sender, receiver and mixed idling");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
